// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the calendar clock RTL.
// No dependencies; simulation builds see the assertions, synthesis sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property checked on every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Condition that must be true on every clock edge outside reset.
`define ASSERT_HOLDS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst, prop, msg)
`define ASSERT_HOLDS(label, clk, rst, cond, msg)
`endif
`endif

// ----- rtl/ccc_pkg.sv -----
// Types, limits and the month length function of the calendar clock counter.
// No dependencies; used by calendar_clock_counter_core.
package ccc_pkg;

   typedef enum logic [2:0] {
      CMD_LOAD      = 3'd0,
      CMD_TICK_FWD  = 3'd1,
      CMD_TICK_BACK = 3'd2,
      CMD_ADJUST    = 3'd3,
      CMD_READ      = 3'd4
   } command_type;

   typedef enum logic [2:0] {
      FIELD_SECOND = 3'd0,
      FIELD_MINUTE = 3'd1,
      FIELD_HOUR   = 3'd2,
      FIELD_DAY    = 3'd3,
      FIELD_MONTH  = 3'd4,
      FIELD_YEAR   = 3'd5
   } field_type;

   localparam logic [5:0]  SECOND_MAX     = 6'd59;
   localparam logic [5:0]  MINUTE_MAX     = 6'd59;
   localparam logic [4:0]  HOUR_MAX       = 5'd23;
   localparam logic [4:0]  HOUR_ADJ_ONE   = 5'd20;
   localparam logic [7:0]  HOUR_DELTA_ONE = 8'd1;
   localparam logic [7:0]  HOUR_DELTA_TEN = 8'd10;
   localparam logic [4:0]  DAYS_LONG      = 5'd31;
   localparam logic [4:0]  DAYS_SHORT     = 5'd30;
   localparam logic [4:0]  DAYS_FEB_LEAP  = 5'd29;
   localparam logic [4:0]  DAYS_FEB       = 5'd28;
   localparam logic [3:0]  MONTH_FEB      = 4'd2;
   localparam logic [3:0]  MONTH_APR      = 4'd4;
   localparam logic [3:0]  MONTH_JUN      = 4'd6;
   localparam logic [3:0]  MONTH_SEP      = 4'd9;
   localparam logic [3:0]  MONTH_NOV      = 4'd11;
   localparam logic [3:0]  MONTH_MAX      = 4'd12;
   localparam logic [13:0] YEAR_MAX       = 14'd9999;
   localparam logic [13:0] YEAR_RESET     = 14'd2000;

   function automatic logic [4:0] month_len(input logic [3:0] month, input logic [13:0] year);
      logic [4:0] len;
      case (month) inside
         MONTH_FEB: len = (year[1:0] == 2'b00) ? DAYS_FEB_LEAP : DAYS_FEB;
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = DAYS_SHORT;
         default: len = DAYS_LONG;
      endcase
      return len;
   endfunction

endpackage

// ----- rtl/calendar_clock_counter_core.sv -----
// Calendar clock counter: command register stage followed by the calendar update.
// Depends on ccc_pkg and assert_macros.svh.
//
//   channel | direction | beat contents
//   --------+-----------+---------------------------------------------------
//   req     | in        | command, field select, delta and six load values
//   rsp     | out       | second, minute, hour, day, month, year after step
//
// One beat per cycle sustained while rsp_ready holds; each request is registered in
// the command stage, then applied to the calendar registers, which also serve as
// the result register.
// Reset sets 00:00:00 on day 1 of month 1 of year 2000 and empties both stages.
// A stalled result holds the calendar; the command stage still takes one more beat.
`include "assert_macros.svh"

module calendar_clock_counter_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [2:0]        req_command,
   input  logic [2:0]        req_field_select,
   input  logic signed [7:0] req_delta,
   input  logic [5:0]        req_load_second,
   input  logic [5:0]        req_load_minute,
   input  logic [4:0]        req_load_hour,
   input  logic [4:0]        req_load_day,
   input  logic [3:0]        req_load_month,
   input  logic [13:0]       req_load_year,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [5:0]        rsp_second_now,
   output logic [5:0]        rsp_minute_now,
   output logic [4:0]        rsp_hour_now,
   output logic [4:0]        rsp_day_now,
   output logic [3:0]        rsp_month_now,
   output logic [13:0]       rsp_year_now
);

   logic              cmd_valid_ff, cmd_valid_in;
   logic [2:0]        cmd_ff;
   logic [2:0]        sel_ff;
   logic signed [7:0] delta_ff;
   logic [5:0]        ld_second_ff, ld_minute_ff;
   logic [4:0]        ld_hour_ff, ld_day_ff;
   logic [3:0]        ld_month_ff;
   logic [13:0]       ld_year_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [5:0]        second_ff, second_in;
   logic [5:0]        minute_ff, minute_in;
   logic [4:0]        hour_ff, hour_in;
   logic [4:0]        day_ff, day_in;
   logic [3:0]        month_ff, month_in;
   logic [13:0]       year_ff, year_in;

   logic              advance;
   logic              req_take;

   assign advance   = cmd_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !cmd_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   assign cmd_valid_in = req_take ? 1'b1 : (advance ? 1'b0 : cmd_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
      end else begin
         cmd_valid_ff <= cmd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_ff       <= req_command;
         sel_ff       <= req_field_select;
         delta_ff     <= req_delta;
         ld_second_ff <= req_load_second;
         ld_minute_ff <= req_load_minute;
         ld_hour_ff   <= req_load_hour;
         ld_day_ff    <= req_load_day;
         ld_month_ff  <= req_load_month;
         ld_year_ff   <= req_load_year;
      end
   end

   always_comb begin
      logic             sec_wrap, min_wrap, hour_wrap, day_wrap, month_wrap;
      logic [4:0]       cur_len, new_len;
      logic [3:0]       new_month;
      logic [13:0]      new_year;
      logic signed [8:0]  delta_9;
      logic signed [8:0]  sum_sec, sum_min, sum_hour, sum_day, sum_month;
      logic signed [15:0] sum_year;
      logic             over;

      second_in = second_ff;
      minute_in = minute_ff;
      hour_in   = hour_ff;
      day_in    = day_ff;
      month_in  = month_ff;
      year_in   = year_ff;

      sec_wrap   = 1'b0;
      min_wrap   = 1'b0;
      hour_wrap  = 1'b0;
      day_wrap   = 1'b0;
      month_wrap = 1'b0;
      new_month  = month_ff;
      new_year   = year_ff;
      new_len    = ccc_pkg::DAYS_LONG;
      over       = 1'b0;
      cur_len    = ccc_pkg::month_len(month_ff, year_ff);
      delta_9    = $signed({delta_ff[7], delta_ff});
      sum_sec    = $signed({3'b000, second_ff}) + delta_9;
      sum_min    = $signed({3'b000, minute_ff}) + delta_9;
      sum_hour   = $signed({4'b0000, hour_ff}) + delta_9;
      sum_day    = $signed({4'b0000, day_ff}) + delta_9;
      sum_month  = $signed({5'b00000, month_ff}) + delta_9;
      sum_year   = $signed({2'b00, year_ff}) + $signed({{8{delta_ff[7]}}, delta_ff});

      unique case (ccc_pkg::command_type'(cmd_ff))
         ccc_pkg::CMD_LOAD: begin
            second_in = (ld_second_ff > ccc_pkg::SECOND_MAX) ? ccc_pkg::SECOND_MAX
                                                             : ld_second_ff;
            minute_in = (ld_minute_ff > ccc_pkg::MINUTE_MAX) ? ccc_pkg::MINUTE_MAX
                                                             : ld_minute_ff;
            hour_in   = (ld_hour_ff > ccc_pkg::HOUR_MAX) ? ccc_pkg::HOUR_MAX : ld_hour_ff;
            if (ld_month_ff == 4'd0) begin
               new_month = 4'd1;
            end else if (ld_month_ff > ccc_pkg::MONTH_MAX) begin
               new_month = ccc_pkg::MONTH_MAX;
            end else begin
               new_month = ld_month_ff;
            end
            new_year = (ld_year_ff > ccc_pkg::YEAR_MAX) ? ccc_pkg::YEAR_MAX : ld_year_ff;
            new_len  = ccc_pkg::month_len(new_month, new_year);
            if (ld_day_ff == 5'd0) begin
               day_in = 5'd1;
            end else if (ld_day_ff > new_len) begin
               day_in = new_len;
            end else begin
               day_in = ld_day_ff;
            end
            month_in = new_month;
            year_in  = new_year;
         end
         ccc_pkg::CMD_TICK_FWD: begin
            sec_wrap   = (second_ff == ccc_pkg::SECOND_MAX);
            min_wrap   = sec_wrap && (minute_ff == ccc_pkg::MINUTE_MAX);
            hour_wrap  = min_wrap && (hour_ff == ccc_pkg::HOUR_MAX);
            day_wrap   = hour_wrap && (day_ff >= cur_len);
            month_wrap = day_wrap && (month_ff >= ccc_pkg::MONTH_MAX);
            second_in  = sec_wrap ? 6'd0 : 6'(second_ff + 6'd1);
            if (sec_wrap) begin
               minute_in = min_wrap ? 6'd0 : 6'(minute_ff + 6'd1);
            end
            if (min_wrap) begin
               hour_in = hour_wrap ? 5'd0 : 5'(hour_ff + 5'd1);
            end
            if (hour_wrap) begin
               day_in = day_wrap ? 5'd1 : 5'(day_ff + 5'd1);
            end
            if (day_wrap) begin
               month_in = month_wrap ? 4'd1 : 4'(month_ff + 4'd1);
            end
            if (month_wrap && (year_ff < ccc_pkg::YEAR_MAX)) begin
               year_in = 14'(year_ff + 14'd1);
            end
         end
         ccc_pkg::CMD_TICK_BACK: begin
            sec_wrap  = (second_ff == 6'd0);
            min_wrap  = sec_wrap && (minute_ff == 6'd0);
            hour_wrap = min_wrap && (hour_ff == 5'd0);
            day_wrap  = hour_wrap && (day_ff <= 5'd1);
            second_in = sec_wrap ? ccc_pkg::SECOND_MAX : 6'(second_ff - 6'd1);
            if (sec_wrap) begin
               minute_in = min_wrap ? ccc_pkg::MINUTE_MAX : 6'(minute_ff - 6'd1);
            end
            if (min_wrap) begin
               hour_in = hour_wrap ? ccc_pkg::HOUR_MAX : 5'(hour_ff - 5'd1);
            end
            if (day_wrap) begin
               month_wrap = (month_ff <= 4'd1);
               new_month  = month_wrap ? ccc_pkg::MONTH_MAX : 4'(month_ff - 4'd1);
               new_year   = (month_wrap && (year_ff != 14'd0)) ? 14'(year_ff - 14'd1)
                                                                 : year_ff;
               month_in   = new_month;
               year_in    = new_year;
               day_in     = ccc_pkg::month_len(new_month, new_year);
            end else if (hour_wrap) begin
               day_in = 5'(day_ff - 5'd1);
            end
         end
         ccc_pkg::CMD_ADJUST: begin
            unique case (sel_ff)
               ccc_pkg::FIELD_SECOND: begin
                  over = !sum_sec[8] && (sum_sec[7:0] > {2'b00, ccc_pkg::SECOND_MAX});
                  second_in = (over || sum_sec[8]) ? 6'd0 : sum_sec[5:0];
               end
               ccc_pkg::FIELD_MINUTE: begin
                  over = !sum_min[8] && (sum_min[7:0] > {2'b00, ccc_pkg::MINUTE_MAX});
                  minute_in = (over || sum_min[8]) ? 6'd0 : sum_min[5:0];
               end
               ccc_pkg::FIELD_HOUR: begin
                  over = !sum_hour[8] && (sum_hour[7:0] > {3'b000, ccc_pkg::HOUR_MAX});
                  if (over && (delta_ff == ccc_pkg::HOUR_DELTA_TEN)) begin
                     hour_in = 5'd0;
                  end else if (over && (delta_ff == ccc_pkg::HOUR_DELTA_ONE)) begin
                     hour_in = ccc_pkg::HOUR_ADJ_ONE;
                  end else if (sum_hour[8]) begin
                     hour_in = 5'd0;
                  end else if (over) begin
                     hour_in = ccc_pkg::HOUR_MAX;
                  end else begin
                     hour_in = sum_hour[4:0];
                  end
               end
               ccc_pkg::FIELD_DAY: begin
                  if (!sum_day[8] && (sum_day[7:0] > {3'b000, cur_len})) begin
                     day_in = 5'd1;
                  end else if (sum_day[8] || (sum_day[7:0] == 8'd0)) begin
                     day_in = cur_len;
                  end else begin
                     day_in = sum_day[4:0];
                  end
               end
               ccc_pkg::FIELD_MONTH: begin
                  if (!sum_month[8] && (sum_month[7:0] > {4'b0000, ccc_pkg::MONTH_MAX})) begin
                     new_month = 4'd1;
                  end else if (sum_month[8] || (sum_month[7:0] == 8'd0)) begin
                     new_month = ccc_pkg::MONTH_MAX;
                  end else begin
                     new_month = sum_month[3:0];
                  end
                  new_len  = ccc_pkg::month_len(new_month, year_ff);
                  month_in = new_month;
                  day_in   = (day_ff > new_len) ? new_len : day_ff;
               end
               ccc_pkg::FIELD_YEAR: begin
                  if (sum_year[15]) begin
                     year_in = 14'd0;
                  end else if (sum_year[14:0] > {1'b0, ccc_pkg::YEAR_MAX}) begin
                     year_in = ccc_pkg::YEAR_MAX;
                  end else begin
                     year_in = sum_year[13:0];
                  end
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         second_ff    <= 6'd0;
         minute_ff    <= 6'd0;
         hour_ff      <= 5'd0;
         day_ff       <= 5'd1;
         month_ff     <= 4'd1;
         year_ff      <= ccc_pkg::YEAR_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            second_ff <= second_in;
            minute_ff <= minute_in;
            hour_ff   <= hour_in;
            day_ff    <= day_in;
            month_ff  <= month_in;
            year_ff   <= year_in;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_second_now = second_ff;
   assign rsp_minute_now = minute_ff;
   assign rsp_hour_now   = hour_ff;
   assign rsp_day_now    = day_ff;
   assign rsp_month_now  = month_ff;
   assign rsp_year_now   = year_ff;

   `ASSERT_HOLDS(a_time_in_range, clock, reset,
                 (second_ff <= ccc_pkg::SECOND_MAX) && (minute_ff <= ccc_pkg::MINUTE_MAX)
                 && (hour_ff <= ccc_pkg::HOUR_MAX),
                 "time of day left its range")
   `ASSERT_HOLDS(a_date_in_range, clock, reset,
                 (day_ff >= 5'd1) && (month_ff >= 4'd1) && (month_ff <= ccc_pkg::MONTH_MAX)
                 && (year_ff <= ccc_pkg::YEAR_MAX),
                 "date left its range")
   `ASSERT_PROP(a_calendar_only_on_advance, clock, reset,
                !advance |=> $stable({second_ff, minute_ff, hour_ff, day_ff, month_ff, year_ff}),
                "calendar changed without a command")
   `ASSERT_PROP(a_advance_gives_result, clock, reset, advance |=> rsp_valid_ff,
                "applied command produced no result")
   `ASSERT_PROP(a_full_blocks_request, clock, reset,
                (cmd_valid_ff && rsp_valid_ff && !rsp_ready) |-> !req_ready,
                "request taken while both stages are full")

endmodule
